### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the Sobel edge magnitude unit
// Clocked property checks reporting through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define SEM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define SEM_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) \
        else $error(msg);

`endif

### hdl/sem_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Geometry limits, register indexes and shared pixel types.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int MaxWidth  = 2048;
    localparam int MaxHeight = 4096;
    localparam int NumLanes  = 4;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int RowW      = $clog2(MaxHeight);
    localparam int WidthW    = 12;
    localparam int HeightW   = 13;
    localparam int ChansW    = 3;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 13;
    localparam int SumW      = 21;
    localparam int SatSum    = 65025;

    localparam logic [CfgIdxW-1:0] CfgWidth  = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CfgHeight = CfgIdxW'(1);
    localparam logic [CfgIdxW-1:0] CfgChans  = CfgIdxW'(2);

    typedef logic [7:0] t_sample;
    // taps of one window column, [0] top row, [2] bottom row
    typedef t_sample [2:0] t_tap3;
    typedef t_sample [NumLanes-1:0] t_pixel;
    // one window column, [0] two rows up, [1] row above, [2] current row
    typedef t_pixel [2:0] t_column;

    typedef struct packed {
        t_pixel older;
        t_pixel prev;
    } t_line;

    typedef struct packed {
        logic push;
        logic run_last;
        logic frame_last;
    } t_merge_ctl;

endpackage

### hdl/sem_if.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude stream interfaces
// Pixel input channel and edge result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sem_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample0;
    logic [7:0] sample1;
    logic [7:0] sample2;
    logic [7:0] sample3;

    modport source (output valid, sample0, sample1, sample2, sample3, input ready);
    modport sink   (input valid, sample0, sample1, sample2, sample3, output ready);
endinterface

interface sem_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] edge0;
    logic [7:0] edge1;
    logic [7:0] edge2;
    logic [7:0] edge3;
    logic       run_last;
    logic       frame_last;

    modport source (output valid, edge0, edge1, edge2, edge3, run_last, frame_last,
                    input ready);
    modport sink   (input valid, edge0, edge1, edge2, edge3, run_last, frame_last,
                    output ready);
endinterface

### hdl/sobel_edge_magnitude_unit.sv
// Sequence: take a pixel, load it into the window, then check each of four
// result slots in turn; each valid slot runs the lanes (squares, square root)
// and is pushed, waiting while o_res stalls; only then is a new pixel taken.
// Throughput: one pixel in flight at a time; results leave through a register.
// Reset: synchronous, active low; clears control, counters and registers to
// 640 x 480, 3 channels. The line memory is not cleared.
// ----------------------------------------------------------------------------
// Sobel edge magnitude unit
// Line memory, 3x3 window, result sequencer and four channel lanes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sobel_edge_magnitude_unit import sem_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sem_in_if.sink              i_pix,
    sem_out_if.source           o_res,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_SCAN, S_CALC, S_PUSH} t_state;

    t_state             r_state;
    logic [WidthW-1:0]  r_width;
    logic [HeightW-1:0] r_height;
    logic [ChansW-1:0]  r_chans;
    logic [ColW-1:0]    r_col;
    logic [RowW-1:0]    r_row;
    t_pixel             r_cur;
    t_line              r_rd;
    t_line              r_mem [MaxWidth];
    t_column            r_win0, r_win1, r_win2;
    logic [3:0]         r_slot_vld;
    logic [1:0]         r_slot;
    logic [1:0]         r_kl_a, r_kl_b;
    logic               r_top2, r_top1;
    logic [3:0]         r_flast;

    logic [WidthW-1:0]  w_eff;
    logic [HeightW-1:0] h_eff;
    logic               xfer, start, lanes_busy, merge_ready;
    logic [1:0]         kl, kc;
    logic               below;
    t_column            lcol, ccol, rcol, lrows, crows, rrows;
    t_pixel             lane_edge;
    logic [NumLanes-1:0] lane_busy;
    logic [3:0]         above;
    t_merge_ctl         mctl;

    function automatic t_column pick(logic [1:0] k, t_column w0, t_column w1, t_column w2);
        t_column col;
        case (k)
            2'd0:    col = w0;
            2'd1:    col = w1;
            default: col = w2;
        endcase
        return col;
    endfunction

    // replicate edge rows above the frame and below the last row
    function automatic t_column rows(t_column w, logic bel, logic top2, logic top1);
        t_column r;
        if (!bel) begin
            r[0] = top2 ? w[0] : w[1];
            r[1] = w[1];
            r[2] = w[2];
        end else begin
            r[0] = top1 ? w[1] : w[2];
            r[1] = w[2];
            r[2] = w[2];
        end
        return r;
    endfunction

    always_comb begin
        w_eff = (r_width == '0) ? WidthW'(1)
              : (r_width > WidthW'(MaxWidth)) ? WidthW'(MaxWidth) : r_width;
        h_eff = (r_height == '0) ? HeightW'(1)
              : (r_height > HeightW'(MaxHeight)) ? HeightW'(MaxHeight) : r_height;
    end

    assign xfer        = i_pix.valid && i_pix.ready;
    assign i_pix.ready = (r_state == S_IDLE);
    assign start       = (r_state == S_SCAN) && r_slot_vld[r_slot];

    always_comb begin
        below = r_slot[1];
        kl    = r_slot[0] ? r_kl_b : r_kl_a;
        kc    = r_slot[0] ? 2'd2 : 2'd1;
        lcol  = pick(kl, r_win0, r_win1, r_win2);
        ccol  = pick(kc, r_win0, r_win1, r_win2);
        rcol  = r_win2;
        lrows = rows(lcol, below, r_top2, r_top1);
        crows = rows(ccol, below, r_top2, r_top1);
        rrows = rows(rcol, below, r_top2, r_top1);
    end

    for (genvar c = 0; c < NumLanes; c++) begin : g_lane
        sem_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (start),
            .i_l     ({lrows[2][c], lrows[1][c], lrows[0][c]}),
            .i_c     ({crows[2][c], crows[1][c], crows[0][c]}),
            .i_r     ({rrows[2][c], rrows[1][c], rrows[0][c]}),
            .o_busy  (lane_busy[c]),
            .o_edge  (lane_edge[c])
        );
    end

    assign lanes_busy = |lane_busy;

    // no valid slot after the current one: this is the last result of the pixel
    assign above = r_slot_vld & ~((4'd2 << r_slot) - 4'd1);

    always_comb begin
        mctl.push       = (r_state == S_PUSH);
        mctl.run_last   = (above == 4'd0);
        mctl.frame_last = r_flast[r_slot];
    end

    sem_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_edge  (lane_edge),
        .i_chans (r_chans),
        .i_ctl   (mctl),
        .o_ready (merge_ready),
        .o_res   (o_res)
    );

    // line memory: read on transfer, write back in S_LOAD, the cycle after
    always_ff @(posedge i_clk) begin
        if (xfer) begin
            r_rd <= r_mem[r_col];
        end
        if (r_state == S_LOAD) begin
            r_mem[r_col] <= '{older: r_rd.prev, prev: r_cur};
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer) begin
            r_cur <= '{i_pix.sample3, i_pix.sample2, i_pix.sample1, i_pix.sample0};
        end
        if (r_state == S_LOAD) begin
            r_win0     <= r_win1;
            r_win1     <= r_win2;
            r_win2     <= '{r_cur, r_rd.prev, r_rd.older};
            r_slot_vld <= {(13'(r_row) == h_eff - 13'd1) && (12'(r_col) == w_eff - 12'd1),
                           (13'(r_row) == h_eff - 13'd1) && (r_col != '0),
                           (r_row != '0) && (12'(r_col) == w_eff - 12'd1),
                           (r_row != '0) && (r_col != '0)};
            r_kl_a     <= (r_col == ColW'(1)) ? 2'd1 : 2'd0;
            r_kl_b     <= (r_col == '0) ? 2'd2 : 2'd1;
            r_top2     <= (r_row > RowW'(1));
            r_top1     <= (r_row != '0);
            r_flast    <= {1'b1,
                           (12'(r_col) == w_eff),
                           (13'(r_row) == h_eff),
                           (13'(r_row) == h_eff) && (12'(r_col) == w_eff)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_width  <= WidthW'(640);
            r_height <= HeightW'(480);
            r_chans  <= ChansW'(3);
            r_col    <= '0;
            r_row    <= '0;
            r_slot   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (xfer) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (12'(r_col) + 12'd1 >= w_eff) begin
                        r_col <= '0;
                        r_row <= (13'(r_row) + 13'd1 >= h_eff) ? '0 : r_row + RowW'(1);
                    end else begin
                        r_col <= r_col + ColW'(1);
                    end
                    r_slot  <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_slot_vld[r_slot]) begin
                        r_state <= S_CALC;
                    end else if (r_slot == 2'd3) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_slot <= r_slot + 2'd1;
                    end
                end
                S_CALC: begin
                    if (!lanes_busy) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (merge_ready) begin
                        if (r_slot == 2'd3) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_slot  <= r_slot + 2'd1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // a geometry write restarts the frame
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgWidth: begin
                        r_width <= i_cfg_data[WidthW-1:0];
                        r_col   <= '0;
                        r_row   <= '0;
                    end
                    CfgHeight: begin
                        r_height <= i_cfg_data[HeightW-1:0];
                        r_col    <= '0;
                        r_row    <= '0;
                    end
                    CfgChans: r_chans <= i_cfg_data[ChansW-1:0];
                    default: ;
                endcase
            end
        end
    end

    `SEM_ASSERT(a_col_in_frame, (12'(r_col) < w_eff), "column counter beyond frame width")
    `SEM_ASSERT(a_load_after_xfer, (r_state == S_LOAD) |-> $past(xfer), "load without a pixel transfer")
    `SEM_ASSERT_RST(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE), "sequencer not idle after reset")

endmodule

### hdl/sem_lane.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude lane
// Gradients, sum of squares and bit-serial square root for one channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sem_lane import sem_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_tap3   i_l,
    input  t_tap3   i_c,
    input  t_tap3   i_r,
    output logic    o_busy,
    output t_sample o_edge
);

    typedef enum logic [1:0] {L_IDLE, L_SQUARE, L_ROOT} t_lstate;

    t_lstate          r_state;
    logic [9:0]       r_agx, r_agy;
    logic [SumW-1:0]  r_sum;
    logic [2:0]       r_bit;
    t_sample          r_root;

    logic [9:0]  sum_r, sum_l, sum_t, sum_b, n_agx, n_agy;
    t_sample     trial;
    logic [15:0] trial_sq;

    always_comb begin
        sum_r = {2'b0, i_r[0]} + {1'b0, i_r[1], 1'b0} + {2'b0, i_r[2]};
        sum_l = {2'b0, i_l[0]} + {1'b0, i_l[1], 1'b0} + {2'b0, i_l[2]};
        sum_t = {2'b0, i_l[0]} + {1'b0, i_c[0], 1'b0} + {2'b0, i_r[0]};
        sum_b = {2'b0, i_l[2]} + {1'b0, i_c[2], 1'b0} + {2'b0, i_r[2]};
        n_agx = (sum_r >= sum_l) ? sum_r - sum_l : sum_l - sum_r;
        n_agy = (sum_b >= sum_t) ? sum_b - sum_t : sum_t - sum_b;
        trial    = r_root | (t_sample'(1) << r_bit);
        trial_sq = trial * trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_agx   <= n_agx;
                        r_agy   <= n_agy;
                        r_state <= L_SQUARE;
                    end
                end
                L_SQUARE: begin
                    r_sum   <= SumW'(r_agx) * SumW'(r_agx) + SumW'(r_agy) * SumW'(r_agy);
                    r_root  <= '0;
                    r_bit   <= 3'd7;
                    r_state <= L_ROOT;
                end
                L_ROOT: begin
                    if (r_sum >= SumW'(SatSum)) begin
                        r_root  <= 8'hFF;
                        r_state <= L_IDLE;
                    end else begin
                        if (SumW'(trial_sq) <= r_sum) begin
                            r_root <= trial;
                        end
                        if (r_bit == 3'd0) begin
                            r_state <= L_IDLE;
                        end
                        r_bit <= r_bit - 3'd1;
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != L_IDLE);
    assign o_edge = r_root;

    `SEM_ASSERT(a_root_floor, ($fell(o_busy) && (r_sum < SumW'(SatSum))) |-> (SumW'(o_edge) * SumW'(o_edge) <= r_sum), "root exceeds sum of squares")
    `SEM_ASSERT(a_root_sat, ($fell(o_busy) && (r_sum >= SumW'(SatSum))) |-> (o_edge == 8'hFF), "large magnitude not saturated")

endmodule

### hdl/sem_merge.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude merge stage
// Gathers lane results, blanks unused channels and holds the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sem_merge import sem_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pixel            i_edge,
    input  logic [ChansW-1:0] i_chans,
    input  t_merge_ctl        i_ctl,
    output logic              o_ready,
    sem_out_if.source         o_res
);

    logic   r_vld;
    t_pixel r_edge;
    logic   r_run_last, r_frame_last;

    logic [ChansW-1:0] nch;
    t_pixel            n_edge;

    always_comb begin
        nch = (i_chans > ChansW'(NumLanes)) ? ChansW'(NumLanes) : i_chans;
        for (int c = 0; c < NumLanes; c++) begin
            n_edge[c] = (ChansW'(c) < nch) ? i_edge[c] : '0;
        end
    end

    assign o_ready = !r_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.push && o_ready) begin
            r_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && o_ready) begin
            r_edge       <= n_edge;
            r_run_last   <= i_ctl.run_last;
            r_frame_last <= i_ctl.frame_last;
        end
    end

    assign o_res.valid      = r_vld;
    assign o_res.edge0      = r_edge[0];
    assign o_res.edge1      = r_edge[1];
    assign o_res.edge2      = r_edge[2];
    assign o_res.edge3      = r_edge[3];
    assign o_res.run_last   = r_run_last;
    assign o_res.frame_last = r_frame_last;

    `SEM_ASSERT(a_valid_from_push, $rose(o_res.valid) |-> $past(i_ctl.push), "result appeared without a push")

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude unit testbench
// Streams pixels through the unit under random idling on both channels,
// predicts every edge result in step with each accepted pixel transfer and
// compares the results field by field, over a range of frame geometries.
// ----------------------------------------------------------------------------
module tb_top;
    import sem_pkg::*;

    typedef struct packed {
        t_pixel edges;
        logic   run_last;
        logic   frame_last;
    } t_edge_res;

    logic i_clk;
    logic i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;

    sem_in_if  pix_if ();
    sem_out_if res_if ();

    sobel_edge_magnitude_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix      (pix_if.sink),
        .o_res      (res_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state
    t_pixel    prev_line [MaxWidth];
    t_pixel    older_line [MaxWidth];
    t_pixel    win [3][3];
    int        col_pos, row_pos;
    int        cfg_w, cfg_h, cfg_ch;
    t_edge_res edge_q [$];

    int  n_fail;
    int  n_pix;
    int  n_res;
    bit  no_idle;
    int  hold_req;
    int  hold_cnt;
    int  rx_gap;

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    initial begin
        #30_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int isqrt_sat(int s);
        int r;
        r = 0;
        if (s >= SatSum) return 255;
        for (int b = 128; b != 0; b = b >> 1)
            if ((r | b) * (r | b) <= s) r = r | b;
        return r;
    endfunction

    // row r (0 top .. 2 bottom) of window column k for the selected output row
    function automatic t_pixel tap(int k, int r, bit below, int cy);
        if (!below) begin
            if (r == 0) return (cy >= 2) ? win[k][0] : win[k][1];
            return win[k][r];
        end
        if (r == 0) return (cy >= 1) ? win[k][1] : win[k][2];
        return win[k][2];
    endfunction

    function automatic void push_edge(int kl, int kc, int kr, bit below, int cy, bit fl);
        t_edge_res e;
        t_pixel l0, l1, l2, c0, c2, r0, r1, r2;
        int nch, gx, gy;
        nch = (cfg_ch > 4) ? 4 : cfg_ch;
        l0 = tap(kl, 0, below, cy);
        l1 = tap(kl, 1, below, cy);
        l2 = tap(kl, 2, below, cy);
        c0 = tap(kc, 0, below, cy);
        c2 = tap(kc, 2, below, cy);
        r0 = tap(kr, 0, below, cy);
        r1 = tap(kr, 1, below, cy);
        r2 = tap(kr, 2, below, cy);
        e = '0;
        for (int c = 0; c < NumLanes; c++) begin
            if (c < nch) begin
                gx = int'(r0[c]) + 2 * int'(r1[c]) + int'(r2[c])
                   - int'(l0[c]) - 2 * int'(l1[c]) - int'(l2[c]);
                gy = int'(l2[c]) + 2 * int'(c2[c]) + int'(r2[c])
                   - int'(l0[c]) - 2 * int'(c0[c]) - int'(r0[c]);
                e.edges[c] = 8'(isqrt_sat(gx * gx + gy * gy));
            end
        end
        e.frame_last = fl;
        edge_q.push_back(e);
    endfunction

    function automatic void predict_pixel(t_pixel cur);
        int w, h, cx, cy, n0;
        bit below, last_row;
        w  = (cfg_w < 1) ? 1 : (cfg_w > MaxWidth) ? MaxWidth : cfg_w;
        h  = (cfg_h < 1) ? 1 : (cfg_h > MaxHeight) ? MaxHeight : cfg_h;
        cx = col_pos;
        cy = row_pos;
        n0 = edge_q.size();
        for (int i = 0; i < 3; i++) begin
            win[0][i] = win[1][i];
            win[1][i] = win[2][i];
        end
        win[2][0] = older_line[cx];
        win[2][1] = prev_line[cx];
        win[2][2] = cur;
        older_line[cx] = prev_line[cx];
        prev_line[cx]  = cur;
        for (int p = 0; p < 2; p++) begin
            below = (p == 1);
            if ((!below && cy >= 1) || (below && cy == h - 1)) begin
                last_row = below || (cy - 1 == h - 1);
                if (cx >= 1)
                    push_edge((cx == 1) ? 1 : 0, 1, 2, below, cy,
                              last_row && (cx - 1 == w - 1));
                if (cx == w - 1)
                    push_edge((cx == 0) ? 2 : 1, 2, 2, below, cy, last_row);
            end
        end
        if (edge_q.size() > n0) edge_q[edge_q.size() - 1].run_last = 1'b1;
        if (cx + 1 >= w) begin
            col_pos = 0;
            row_pos = (cy + 1 >= h) ? 0 : cy + 1;
        end else begin
            col_pos = cx + 1;
        end
    endfunction

    // result receiver: random idling, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold_cnt = 0;
            rx_gap   = 0;
        end else begin
            if (hold_req > 0) begin
                hold_cnt = hold_req;
                hold_req = 0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                res_if.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                res_if.ready <= 1'b0;
            end else begin
                rx_gap = pick_gap();
                res_if.ready <= (rx_gap == 0);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_edge_res exp_r;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            n_res++;
            if (edge_q.size() == 0) begin
                $error("unexpected result transfer");
                n_fail++;
            end else begin
                exp_r = edge_q.pop_front();
                if (res_if.edge0 !== exp_r.edges[0]) begin
                    $error("edge0 expected %0d got %0d", exp_r.edges[0], res_if.edge0);
                    n_fail++;
                end
                if (res_if.edge1 !== exp_r.edges[1]) begin
                    $error("edge1 expected %0d got %0d", exp_r.edges[1], res_if.edge1);
                    n_fail++;
                end
                if (res_if.edge2 !== exp_r.edges[2]) begin
                    $error("edge2 expected %0d got %0d", exp_r.edges[2], res_if.edge2);
                    n_fail++;
                end
                if (res_if.edge3 !== exp_r.edges[3]) begin
                    $error("edge3 expected %0d got %0d", exp_r.edges[3], res_if.edge3);
                    n_fail++;
                end
                if (res_if.run_last !== exp_r.run_last) begin
                    $error("run_last expected %0b got %0b", exp_r.run_last,
                           res_if.run_last);
                    n_fail++;
                end
                if (res_if.frame_last !== exp_r.frame_last) begin
                    $error("frame_last expected %0b got %0b", exp_r.frame_last,
                           res_if.frame_last);
                    n_fail++;
                end
            end
        end
    end

    task automatic send_pixel(t_pixel p);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid   <= 1'b1;
        pix_if.sample0 <= p[0];
        pix_if.sample1 <= p[1];
        pix_if.sample2 <= p[2];
        pix_if.sample3 <= p[3];
        do @(posedge i_clk); while (!pix_if.ready);
        predict_pixel(p);
        n_pix++;
    endtask

    function automatic t_pixel rand_pixel();
        return t_pixel'($urandom());
    endfunction

    // drain, let the unit settle, then write one register
    task automatic write_reg(logic [CfgIdxW-1:0] idx, int value);
        pix_if.valid <= 1'b0;
        while (edge_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CfgDataW'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CfgWidth) begin
            cfg_w = value & 12'hFFF;
            col_pos = 0;
            row_pos = 0;
        end else if (idx == CfgHeight) begin
            cfg_h = value & 13'h1FFF;
            col_pos = 0;
            row_pos = 0;
        end else if (idx == CfgChans) begin
            cfg_ch = value & 3'h7;
        end
    endtask

    task automatic set_geometry(int w, int h, int ch);
        write_reg(CfgWidth, w);
        write_reg(CfgHeight, h);
        write_reg(CfgChans, ch);
    endtask

    task automatic test_defaults();
        for (int i = 0; i < 4; i++) send_pixel(rand_pixel());
    endtask

    task automatic test_directed();
        t_pixel px [4];
        px[0] = '0;
        px[1] = '1;
        px[2] = {8'hFF, 8'h00, 8'hFF, 8'h00};
        px[3] = {8'h00, 8'hFF, 8'h00, 8'hFF};
        // strong edges on a 3x3 frame, all four channels
        set_geometry(3, 3, 4);
        for (int i = 0; i < 9; i++) send_pixel(px[(i % 3 == 0) ? 1 : (i % 4)]);
        // single pixel frames, channel count above four acts as four
        set_geometry(1, 1, 7);
        send_pixel(px[1]);
        send_pixel(px[2]);
        // channel count zero gives all-zero edges
        write_reg(CfgChans, 0);
        send_pixel(px[3]);
        set_geometry(2, 2, 1);
        for (int i = 0; i < 4; i++) send_pixel(px[i]);
    endtask

    task automatic test_out_of_range();
        // zero width and height clamp to one
        set_geometry(0, 0, 2);
        send_pixel(rand_pixel());
        send_pixel(rand_pixel());
        // widest value clamps to the maximum width, abandoned mid-row
        set_geometry(4095, 1, 4);
        for (int i = 0; i < 8; i++) send_pixel(rand_pixel());
        // largest in-range width, also abandoned
        write_reg(CfgWidth, MaxWidth);
        for (int i = 0; i < 4; i++) send_pixel(rand_pixel());
        // tallest value clamps, restart after a few rows
        set_geometry(2, 8191, 3);
        for (int i = 0; i < 6; i++) send_pixel(rand_pixel());
        write_reg(CfgHeight, MaxHeight);
        for (int i = 0; i < 4; i++) send_pixel(rand_pixel());
    endtask

    task automatic test_backpressure();
        set_geometry(8, 4, 4);
        hold_req = 400;
        for (int i = 0; i < 32; i++) send_pixel(rand_pixel());
    endtask

    task automatic test_random_frames();
        int w, h, n, start;
        start = n_pix;
        while (n_pix - start < 340) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 70) : $urandom_range(1, 12);
            h = $urandom_range(1, 6);
            set_geometry(w, h, $urandom_range(0, 7));
            no_idle = ($urandom_range(0, 3) == 0);
            n = w * h;
            // now and then abandon the frame part way through
            if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
            if (n > 340 - (n_pix - start)) n = 340 - (n_pix - start);
            for (int i = 0; i < n; i++) send_pixel(rand_pixel());
            no_idle = 1'b0;
        end
    endtask

    initial begin
        n_fail = 0; n_pix = 0; n_res = 0;
        no_idle = 1'b0; hold_req = 0;
        cfg_w = 640; cfg_h = 480; cfg_ch = 3;
        col_pos = 0; row_pos = 0;
        for (int i = 0; i < MaxWidth; i++) begin
            prev_line[i]  = '0;
            older_line[i] = '0;
        end
        for (int k = 0; k < 3; k++)
            for (int r = 0; r < 3; r++) win[k][r] = '0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        pix_if.valid   = 1'b0;
        pix_if.sample0 = '0;
        pix_if.sample1 = '0;
        pix_if.sample2 = '0;
        pix_if.sample3 = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_directed();
        test_out_of_range();
        test_backpressure();
        test_random_frames();

        pix_if.valid <= 1'b0;
        while (edge_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Covered %0d pixel transfers and %0d edge results over small,",
                 n_pix, n_res);
        $display("clamped and widest geometries, channel counts 0 to 7, with stalls.");
        if (n_fail == 0 && edge_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
